/* rtl/core/circular_buffer_deque_top_defines.svh */
// assertion helpers used by circular_buffer_deque_top
`ifndef CIRCULAR_BUFFER_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_BUFFER_DEQUE_TOP_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define CBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define CBD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/cbd_pkg.sv */
package cbd_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned ENTRY_W = 31;
    localparam int unsigned FILL_W  = 11;

    localparam logic signed [VALUE_W-1:0] NONE_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_POP_FRONT  = 2'd1,
        FN_PUSH_BACK  = 2'd2,
        FN_POP_BACK   = 2'd3
    } t_func;

    typedef struct packed {
        t_func                     func;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic                      was_empty;
        logic                      push_dropped;
        logic                      matched;
        logic                      all_matched;
        logic [FILL_W-1:0]         fill_count;
    } t_result;

endpackage

/* rtl/core/cbd_stream_if.sv */
interface cbd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/cbd_ram.sv */
module cbd_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/circular_buffer_deque_top.sv */
// channel | dir | payload                                    | beat
// i_cmd   | in  | func, value                                | one command
// o_res   | out | popped_value, was_empty, push_dropped,     | one result
//         |     | matched, all_matched, fill_count           |
//
// a push or an empty pop writes its result straight into the pending register,
// a pop with data first reads the ram in S_READ; each result then waits in the
// pending register before the output register. one command in flight; the next
// is taken once the pending result has moved into the output register
// synchronous active-low reset clears pointers, count and flags, not the ram
// a stalled output holds one result while the next command is worked on
`include "circular_buffer_deque_top_defines.svh"

module circular_buffer_deque_top #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cbd_stream_if.sink   i_cmd,
    cbd_stream_if.source o_res
);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back, n_back;
    logic [CW-1:0] r_count, n_count;
    logic          r_mismatch, n_mismatch;
    logic signed [cbd_pkg::VALUE_W-1:0] r_exp;

    cbd_pkg::t_result r_res, n_res;
    logic             r_res_vld, n_res_vld;
    cbd_pkg::t_result r_out;
    logic             r_out_vld;

    cbd_pkg::t_cmd cmd;
    logic accept, move, full, empty;
    logic drop_push;
    logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [cbd_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;
    logic signed [cbd_pkg::VALUE_W-1:0] rd_value;
    logic rd_match;

    assign cmd    = i_cmd.payload;
    assign i_cmd.ready = i_rst_n && (r_state == S_IDLE) && !r_res_vld;
    assign accept = i_cmd.valid && i_cmd.ready;
    assign move   = r_res_vld && (!r_out_vld || o_res.ready);

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);
    assign drop_push = accept && full &&
                       (cmd.func == cbd_pkg::FN_PUSH_FRONT || cmd.func == cbd_pkg::FN_PUSH_BACK);

    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign back_inc  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;
    assign back_dec  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;

    assign mem_wdata = cmd.value[cbd_pkg::ENTRY_W-1:0];
    assign rd_value  = {1'b0, mem_rdata};
    assign rd_match  = (rd_value == r_exp);

    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_back     = r_back;
        n_count    = r_count;
        n_mismatch = r_mismatch;
        n_res      = r_res;
        n_res_vld  = r_res_vld && !move;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_back;
        mem_raddr  = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res.popped_value = cbd_pkg::NONE_VALUE;
                    n_res.was_empty    = 1'b0;
                    n_res.push_dropped = 1'b0;
                    n_res.matched      = 1'b1;
                    case (cmd.func) inside
                        cbd_pkg::FN_PUSH_FRONT, cbd_pkg::FN_PUSH_BACK: begin
                            n_res_vld = 1'b1;
                            if (full) begin
                                n_res.push_dropped = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                                if (cmd.func == cbd_pkg::FN_PUSH_FRONT) begin
                                    mem_waddr = front_dec;
                                    n_front   = front_dec;
                                end else begin
                                    mem_waddr = r_back;
                                    n_back    = back_inc;
                                end
                            end
                        end
                        default: begin
                            if (empty) begin
                                // empty pop answers at once with the none value
                                n_res_vld       = 1'b1;
                                n_res.was_empty = 1'b1;
                                n_res.matched   = (cmd.value == cbd_pkg::NONE_VALUE);
                                n_mismatch      = r_mismatch ||
                                                  (cmd.value != cbd_pkg::NONE_VALUE);
                            end else begin
                                mem_re  = 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = S_READ;
                                if (cmd.func == cbd_pkg::FN_POP_FRONT) begin
                                    mem_raddr = r_front;
                                    n_front   = front_inc;
                                end else begin
                                    mem_raddr = back_dec;
                                    n_back    = back_dec;
                                end
                            end
                        end
                    endcase
                    n_res.all_matched = !n_mismatch;
                    n_res.fill_count  = cbd_pkg::FILL_W'(n_count);
                end
            end
            S_READ: begin
                n_state            = S_IDLE;
                n_res_vld          = 1'b1;
                n_mismatch         = r_mismatch || !rd_match;
                n_res.popped_value = rd_value;
                n_res.was_empty    = 1'b0;
                n_res.push_dropped = 1'b0;
                n_res.matched      = rd_match;
                n_res.all_matched  = !n_mismatch;
                n_res.fill_count   = cbd_pkg::FILL_W'(r_count);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_front    <= '0;
            r_back     <= '0;
            r_count    <= '0;
            r_mismatch <= 1'b0;
            r_res_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_front    <= n_front;
            r_back     <= n_back;
            r_count    <= n_count;
            r_mismatch <= n_mismatch;
            r_res_vld  <= n_res_vld;
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_exp <= cmd.value;
        end
        if (move) begin
            r_out <= r_res;
        end
    end

    cbd_ram #(
        .WIDTH (cbd_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    `CBD_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_res.valid,
        "output valid right after reset")
    `CBD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `CBD_ASSERT(a_read_lands, i_clk, i_rst_n, (r_state == S_READ) |=> r_res_vld,
        "read result lost")
    `CBD_ASSERT(a_pending_moves, i_clk, i_rst_n,
        (r_res_vld && !r_out_vld) |=> (r_out_vld && !r_res_vld), "pending result stuck")
    `CBD_ASSERT(a_drop_when_full, i_clk, i_rst_n,
        drop_push |=> ($stable(r_count) && r_res.push_dropped), "full push changed state")
endmodule
